[hw/rtl/smsc_pkg.sv]
// Shared widths, limits and seven-segment encoding for the settable clock that counts minutes and seconds.
// No dependencies; imported by smsc_knob_scale, settable_minute_second_clock_unit and tb.
package smsc_pkg;

    localparam int unsigned KNOB_W    = 10;
    localparam int unsigned COUNT_W   = 6;
    localparam int unsigned MODE_W    = 3;
    localparam int unsigned SEG_W     = 8;
    localparam int unsigned COUNT_MAX = 59;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [SEG_W-1:0]   seg_t;

    // Segment codes for digits 0..9, active low
    localparam seg_t SEG_TABLE [10] = '{
        8'h40, 8'hF9, 8'h24, 8'h30, 8'h19, 8'h12, 8'h02, 8'h78, 8'h00, 8'h10
    };

    // Tens digit of a 6-bit count (0..6)
    function automatic logic [2:0] tens_of(input count_t v);
        logic [2:0] t;
        if (v >= COUNT_W'(60))      t = 3'd6;
        else if (v >= COUNT_W'(50)) t = 3'd5;
        else if (v >= COUNT_W'(40)) t = 3'd4;
        else if (v >= COUNT_W'(30)) t = 3'd3;
        else if (v >= COUNT_W'(20)) t = 3'd2;
        else if (v >= COUNT_W'(10)) t = 3'd1;
        else                        t = 3'd0;
        return t;
    endfunction

    // Ones digit of a 6-bit count (0..9)
    function automatic logic [3:0] ones_of(input count_t v);
        logic [2:0]   t;
        count_t       r;
        t = tens_of(v);
        r = v - COUNT_W'(t) * COUNT_W'(10);
        return r[3:0];
    endfunction

    // Segment code for a digit; codes beyond 9 never occur
    function automatic seg_t seg_of(input logic [3:0] d);
        seg_t s;
        if (d <= 4'd9) s = SEG_TABLE[d];
        else           s = SEG_TABLE[0];
        return s;
    endfunction

endpackage

[hw/rtl/smsc_knob_scale.sv]
// Knob scaling: maps a raw knob sample to a 0..59 setting, rounded half up.
// Depends on smsc_pkg for widths and the count limit.
module smsc_knob_scale
    import smsc_pkg::*;
#(
    parameter int unsigned KNOB_FULL_SCALE = 1023
)
(
    input  logic [KNOB_W-1:0] knob_sample,
    output count_t            knob_value
);

    // hit[j] is set when the rounded value reaches at least j
    logic [COUNT_MAX+1:0] hit;
    logic [COUNT_MAX:0]   edge_hit;

    assign hit[0]           = 1'b1;
    assign hit[COUNT_MAX+1] = 1'b0;

    // Compare the sample against the rounding threshold of each step
    for (genvar j = 1; j <= COUNT_MAX; j++) begin : g_thr
        localparam longint unsigned THR =
            (longint'(KNOB_FULL_SCALE) * longint'(2 * j - 1) + 119) / 120;
        assign hit[j] = (64'(knob_sample) >= 64'(THR));
    end

    // Mark the top of the thermometer code
    for (genvar j = 0; j <= COUNT_MAX; j++) begin : g_edge
        assign edge_hit[j] = hit[j] & ~hit[j+1];
    end

    // Turn the one-hot top position into its index
    always_comb
    begin
        knob_value = '0;
        for (int j = 0; j <= int'(COUNT_MAX); j++)
        begin
            knob_value = knob_value | (edge_hit[j] ? COUNT_W'(j) : '0);
        end
    end

endmodule

[hw/rtl/settable_minute_second_clock_unit.sv]
// Top level of the settable clock that counts minutes and seconds, with seven-segment outputs.
// Depends on smsc_pkg and smsc_knob_scale.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one poll sample per
//   transaction: button level, knob sample and tick flag. Output channel
//   (out_valid / out_stall) returns one transaction per input: minutes,
//   seconds, mode and four segment codes (minutes tens/ones, seconds
//   tens/ones).
//   Each transaction passes the input register, then the result register.
//   Throughput: one transaction per cycle while out_stall is low; the knob
//   scaling sits in front of the input register and the mode/count update
//   between the input and result registers.
//   Stall: while out_stall holds a waiting result, the input register still
//   takes one more transaction; in_stall rises only when both stages are full.
//   Reset (rst_n low): mode, minutes and seconds go to zero and both stages
//   empty. Without a tick, counting modes hold the time; set modes load the
//   knob value into minutes or seconds.
module settable_minute_second_clock_unit
    import smsc_pkg::*;
#(
    parameter int unsigned KNOB_FULL_SCALE = 1023
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              button,
    input  logic [KNOB_W-1:0] knob_sample,
    input  logic              tick,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [COUNT_W-1:0] minutes,
    output logic [COUNT_W-1:0] seconds,
    output logic [MODE_W-1:0] mode,
    output logic [SEG_W-1:0]  minute_tens_segments,
    output logic [SEG_W-1:0]  minute_ones_segments,
    output logic [SEG_W-1:0]  second_tens_segments,
    output logic [SEG_W-1:0]  second_ones_segments
);

    typedef enum logic [MODE_W-1:0] {
        MODE_COUNT      = 3'd0,
        MODE_PRESS_MIN  = 3'd1,
        MODE_SET_MIN    = 3'd2,
        MODE_PRESS_SEC  = 3'd3,
        MODE_SET_SEC    = 3'd4,
        MODE_PRESS_RUN  = 3'd5,
        MODE_RUN        = 3'd6,
        MODE_HOLD       = 3'd7
    } mode_t;

    count_t knob_value;

    logic   s1_valid_reg;
    logic   s1_button_reg;
    logic   s1_tick_reg;
    count_t s1_knob_reg;

    mode_t  mode_reg,   mode_next;
    count_t minute_reg, minute_next;
    count_t second_reg, second_next;
    logic   out_valid_reg;
    seg_t   min_tens_reg, min_ones_reg, sec_tens_reg, sec_ones_reg;

    logic   s1_advance;
    logic   in_take;

    // Scale the knob ahead of the input register
    smsc_knob_scale #(
        .KNOB_FULL_SCALE (KNOB_FULL_SCALE)
    ) u_knob_scale (
        .knob_sample (knob_sample),
        .knob_value  (knob_value)
    );

    // Handshake: advance the input stage when the result register is free
    assign s1_advance = s1_valid_reg & (~out_valid_reg | ~out_stall);
    assign in_stall   = s1_valid_reg & ~s1_advance;
    assign in_take    = in_valid & ~in_stall;

    // Step the mode machine on the button level
    always_comb
    begin
        mode_next = mode_reg;
        unique case (mode_reg)
            MODE_COUNT:     if (s1_button_reg)  mode_next = MODE_PRESS_MIN;
            MODE_PRESS_MIN: if (!s1_button_reg) mode_next = MODE_SET_MIN;
            MODE_SET_MIN:   if (s1_button_reg)  mode_next = MODE_PRESS_SEC;
            MODE_PRESS_SEC: if (!s1_button_reg) mode_next = MODE_SET_SEC;
            MODE_SET_SEC:   if (s1_button_reg)  mode_next = MODE_PRESS_RUN;
            MODE_PRESS_RUN: if (!s1_button_reg) mode_next = MODE_RUN;
            MODE_RUN:       if (s1_button_reg)  mode_next = MODE_PRESS_MIN;
            MODE_HOLD:      mode_next = MODE_HOLD;
            default:        mode_next = mode_reg;
        endcase
    end

    // Count on a tick in a counting mode, or load the knob in a set mode
    always_comb
    begin
        minute_next = minute_reg;
        second_next = second_reg;
        if ((mode_next == MODE_COUNT || mode_next == MODE_RUN) && s1_tick_reg)
        begin
            if (second_reg >= COUNT_W'(COUNT_MAX))
            begin
                second_next = '0;
                minute_next = (minute_reg >= COUNT_W'(COUNT_MAX)) ? '0
                                                                  : minute_reg + count_t'(1);
            end
            else
            begin
                second_next = second_reg + count_t'(1);
            end
        end
        else if (mode_next == MODE_SET_MIN)
        begin
            minute_next = s1_knob_reg;
        end
        else if (mode_next == MODE_SET_SEC)
        begin
            second_next = s1_knob_reg;
        end
    end

    // Hold the input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Capture the input transaction
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_button_reg <= button;
            s1_tick_reg   <= tick;
            s1_knob_reg   <= knob_value;
        end
    end

    // Update clock state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_COUNT;
            minute_reg    <= '0;
            second_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_advance)
            begin
                mode_reg   <= mode_next;
                minute_reg <= minute_next;
                second_reg <= second_next;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load the segment codes with the new time
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            min_tens_reg <= seg_of({1'b0, tens_of(minute_next)});
            min_ones_reg <= seg_of(ones_of(minute_next));
            sec_tens_reg <= seg_of({1'b0, tens_of(second_next)});
            sec_ones_reg <= seg_of(ones_of(second_next));
        end
    end

    assign out_valid            = out_valid_reg;
    assign minutes              = minute_reg;
    assign seconds              = second_reg;
    assign mode                 = mode_reg;
    assign minute_tens_segments = min_tens_reg;
    assign minute_ones_segments = min_ones_reg;
    assign second_tens_segments = sec_tens_reg;
    assign second_ones_segments = sec_ones_reg;

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for settable_minute_second_clock_unit: directed table, then
// random button/knob/tick sequences checked against an in-file clock predictor.
// Depends on smsc_pkg and the RTL of the clock unit.
module tb
    import smsc_pkg::*;
();

    localparam int KNOB_FS       = 1023;
    localparam int RANDOM_ITEMS  = 1330;
    localparam int QUIET_LIMIT   = 1000;
    localparam int HOLD_CYCLES   = 60;
    localparam int HOLD_AFTER    = 400;
    localparam int DRAIN_AFTER   = 600;
    localparam int N_DIRECTED    = 23;

    typedef enum logic [2:0] {
        MODE_RUN, MODE_PRESS_MIN, MODE_SET_MIN, MODE_PRESS_SEC,
        MODE_SET_SEC, MODE_PRESS_RUN, MODE_RERUN, MODE_UNUSED
    } clock_mode_e;

    typedef struct packed {
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        clock_mode_e mode;
        logic [7:0]  min_tens;
        logic [7:0]  min_ones;
        logic [7:0]  sec_tens;
        logic [7:0]  sec_ones;
    } display_t;

    typedef struct packed {
        logic        button;
        logic [9:0]  knob;
        logic        tick;
        logic        known;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        clock_mode_e mode;
    } stim_row_t;

    // Active-low segment codes for digits 0..9
    localparam logic [7:0] DIGIT_SEG [10] = '{
        8'h40, 8'hF9, 8'h24, 8'h30, 8'h19, 8'h12, 8'h02, 8'h78, 8'h00, 8'h10
    };

    // Directed walk: reset state, tick in every mode class, knob extremes and
    // rounding edges, double wrap at 59:59, press while counting again
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{1'b0, 10'd0,    1'b0, 1'b1, 6'd0,  6'd0,  MODE_RUN},
        '{1'b0, 10'd1023, 1'b1, 1'b1, 6'd0,  6'd1,  MODE_RUN},
        '{1'b1, 10'd1023, 1'b1, 1'b1, 6'd0,  6'd1,  MODE_PRESS_MIN},
        '{1'b1, 10'd0,    1'b1, 1'b1, 6'd0,  6'd1,  MODE_PRESS_MIN},
        '{1'b0, 10'd1023, 1'b0, 1'b1, 6'd59, 6'd1,  MODE_SET_MIN},
        '{1'b0, 10'd0,    1'b1, 1'b1, 6'd0,  6'd1,  MODE_SET_MIN},
        '{1'b0, 10'd8,    1'b0, 1'b0, 6'd0,  6'd0,  MODE_RUN},
        '{1'b0, 10'd9,    1'b0, 1'b0, 6'd0,  6'd0,  MODE_RUN},
        '{1'b0, 10'd1005, 1'b1, 1'b0, 6'd0,  6'd0,  MODE_RUN},
        '{1'b0, 10'd1023, 1'b0, 1'b1, 6'd59, 6'd1,  MODE_SET_MIN},
        '{1'b1, 10'd512,  1'b1, 1'b1, 6'd59, 6'd1,  MODE_PRESS_SEC},
        '{1'b0, 10'd0,    1'b1, 1'b1, 6'd59, 6'd0,  MODE_SET_SEC},
        '{1'b0, 10'd1023, 1'b0, 1'b1, 6'd59, 6'd59, MODE_SET_SEC},
        '{1'b1, 10'd0,    1'b1, 1'b1, 6'd59, 6'd59, MODE_PRESS_RUN},
        '{1'b0, 10'd700,  1'b1, 1'b1, 6'd0,  6'd0,  MODE_RERUN},
        '{1'b0, 10'd0,    1'b1, 1'b1, 6'd0,  6'd1,  MODE_RERUN},
        '{1'b0, 10'd0,    1'b0, 1'b1, 6'd0,  6'd1,  MODE_RERUN},
        '{1'b1, 10'd0,    1'b0, 1'b1, 6'd0,  6'd1,  MODE_PRESS_MIN},
        '{1'b0, 10'd341,  1'b0, 1'b0, 6'd0,  6'd0,  MODE_RUN},
        '{1'b1, 10'd0,    1'b0, 1'b0, 6'd0,  6'd0,  MODE_RUN},
        '{1'b0, 10'd853,  1'b0, 1'b0, 6'd0,  6'd0,  MODE_RUN},
        '{1'b1, 10'd0,    1'b1, 1'b0, 6'd0,  6'd0,  MODE_RUN},
        '{1'b0, 10'd0,    1'b1, 1'b0, 6'd0,  6'd0,  MODE_RUN}
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              button = 1'b0;
    logic [KNOB_W-1:0] knob_sample = '0;
    logic              tick = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [COUNT_W-1:0] minutes;
    logic [COUNT_W-1:0] seconds;
    logic [MODE_W-1:0] mode;
    logic [SEG_W-1:0]  minute_tens_segments;
    logic [SEG_W-1:0]  minute_ones_segments;
    logic [SEG_W-1:0]  second_tens_segments;
    logic [SEG_W-1:0]  second_ones_segments;

    // Predicted clock state
    clock_mode_e model_mode = MODE_RUN;
    logic [5:0]  model_min = '0;
    logic [5:0]  model_sec = '0;

    display_t    pending_display [$];
    display_t    head;
    int          mismatch_count = 0;
    int          results_seen = 0;
    int          rcv_cycle = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          burst_left = 0;
    int          items_sent = 0;
    int          quiet_cycles = 0;

    settable_minute_second_clock_unit #(
        .KNOB_FULL_SCALE (KNOB_FS)
    ) u_top (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .button               (button),
        .knob_sample          (knob_sample),
        .tick                 (tick),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .minutes              (minutes),
        .seconds              (seconds),
        .mode                 (mode),
        .minute_tens_segments (minute_tens_segments),
        .minute_ones_segments (minute_ones_segments),
        .second_tens_segments (second_tens_segments),
        .second_ones_segments (second_ones_segments)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Scale a knob sample to 0..59, rounding half up
    function automatic logic [5:0] knob_to_count(input logic [9:0] sample);
        longint v;
        v = (longint'(sample) * 120 + KNOB_FS) / (2 * KNOB_FS);
        if (v > 59)
            v = 59;
        return 6'(v);
    endfunction

    // Build the full display for a time and mode
    function automatic display_t make_display(input logic [5:0] mins, input logic [5:0] secs,
                                              input clock_mode_e m);
        display_t d;
        d.minutes  = mins;
        d.seconds  = secs;
        d.mode     = m;
        d.min_tens = DIGIT_SEG[(mins / 10) % 10];
        d.min_ones = DIGIT_SEG[mins % 10];
        d.sec_tens = DIGIT_SEG[(secs / 10) % 10];
        d.sec_ones = DIGIT_SEG[secs % 10];
        return d;
    endfunction

    // Advance the predicted clock by one poll sample
    task automatic clock_model_step(input logic b, input logic [9:0] k, input logic t);
        case (model_mode)
            MODE_RUN:       if (b)  model_mode = MODE_PRESS_MIN;
            MODE_PRESS_MIN: if (!b) model_mode = MODE_SET_MIN;
            MODE_SET_MIN:   if (b)  model_mode = MODE_PRESS_SEC;
            MODE_PRESS_SEC: if (!b) model_mode = MODE_SET_SEC;
            MODE_SET_SEC:   if (b)  model_mode = MODE_PRESS_RUN;
            MODE_PRESS_RUN: if (!b) model_mode = MODE_RERUN;
            MODE_RERUN:     if (b)  model_mode = MODE_PRESS_MIN;
            default: ;
        endcase
        if ((model_mode == MODE_RUN || model_mode == MODE_RERUN) && t)
        begin
            if (model_sec >= 6'd59)
            begin
                model_sec = '0;
                model_min = (model_min >= 6'd59) ? 6'd0 : model_min + 6'd1;
            end
            else
                model_sec = model_sec + 6'd1;
        end
        else if (model_mode == MODE_SET_MIN)
            model_min = knob_to_count(k);
        else if (model_mode == MODE_SET_SEC)
            model_sec = knob_to_count(k);
    endtask

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Drop valid, scrambling the idle payload; the argument n sets how long
    task automatic idle_for(input int n);
        repeat (n)
        begin
            in_valid    <= 1'b0;
            button      <= 1'($urandom);
            knob_sample <= 10'($urandom);
            tick        <= 1'($urandom);
            @(posedge clk);
        end
    endtask

    // Offer one sample, possibly after an idle gap, and hold it until the block takes it
    task automatic offer_sample(input logic b, input logic [9:0] k, input logic t);
        if (burst_left == 0)
        begin
            if (hold_left == 0)
                idle_for($urandom_range(1, 12));
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid    <= 1'b1;
        button      <= b;
        knob_sample <= k;
        tick        <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_predicted(input logic b, input logic [9:0] k, input logic t);
        offer_sample(b, k, t);
        clock_model_step(b, k, t);
        pending_display.push_back(make_display(model_min, model_sec, model_mode));
        items_sent++;
    endtask

    // Knob values biased toward full scale, zero and rounding edges
    function automatic logic [9:0] pick_knob();
        int j;
        logic [9:0] v;
        j = $urandom_range(0, 59);
        case ($urandom_range(0, 3))
            0: v = 10'($urandom);
            1: v = 10'($urandom_range(990, 1023));
            2: v = 10'($urandom_range(0, 20));
            default: v = 10'(((2 * j + 1) * KNOB_FS) / 120 + $urandom_range(0, 1));
        endcase
        return v;
    endfunction

    task automatic press_button();
        repeat ($urandom_range(1, 3))
            send_predicted(1'b1, pick_knob(), 1'($urandom));
    endtask

    task automatic turn_knob();
        repeat ($urandom_range(1, 4))
            send_predicted(1'b0, pick_knob(), 1'($urandom));
    endtask

    // Full setting pass: minutes, seconds, back to counting, then tick a while
    task automatic set_and_run();
        press_button();
        turn_knob();
        press_button();
        turn_knob();
        press_button();
        repeat ($urandom_range(1, 80))
            send_predicted(1'b0, pick_knob(), 1'($urandom_range(0, 9) < 8));
    endtask

    // Stop offering and wait for every pending result
    task automatic wait_all_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_display.size() != 0);
    endtask

    // Stimulus
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            offer_sample(DIRECTED[i].button, DIRECTED[i].knob, DIRECTED[i].tick);
            clock_model_step(DIRECTED[i].button, DIRECTED[i].knob, DIRECTED[i].tick);
            if (DIRECTED[i].known)
                pending_display.push_back(make_display(DIRECTED[i].minutes,
                                                       DIRECTED[i].seconds,
                                                       DIRECTED[i].mode));
            else
                pending_display.push_back(make_display(model_min, model_sec, model_mode));
        end
        wait_all_results();

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) < 7)
                set_and_run();
            else
                repeat ($urandom_range(1, 20))
                    send_predicted(1'($urandom), 10'($urandom), 1'($urandom));
            if (items_sent >= DRAIN_AFTER && items_sent < DRAIN_AFTER + 100)
                wait_all_results();
        end

        wait_all_results();
        repeat (6) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: check each transaction, then pick the next stall level
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (pending_display.size() == 0)
                    flag_mismatch("unexpected result minutes", minutes, 0);
                else
                begin
                    head = pending_display.pop_front();
                    if (minutes != head.minutes)
                        flag_mismatch("minutes", minutes, head.minutes);
                    if (seconds != head.seconds)
                        flag_mismatch("seconds", seconds, head.seconds);
                    if (mode != head.mode)
                        flag_mismatch("mode", mode, head.mode);
                    if (minute_tens_segments != head.min_tens)
                        flag_mismatch("minute_tens_segments", minute_tens_segments,
                                      head.min_tens);
                    if (minute_ones_segments != head.min_ones)
                        flag_mismatch("minute_ones_segments", minute_ones_segments,
                                      head.min_ones);
                    if (second_tens_segments != head.sec_tens)
                        flag_mismatch("second_tens_segments", second_tens_segments,
                                      head.sec_tens);
                    if (second_ones_segments != head.sec_ones)
                        flag_mismatch("second_ones_segments", second_ones_segments,
                                      head.sec_ones);
                end
            end

            // Hold off once for a long stretch so both stages fill
            if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                case ((rcv_cycle / 200) % 4)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 9) < 3);
                    2: out_stall <= ($urandom_range(0, 9) < 7);
                    default: out_stall <= ((rcv_cycle % 5) < 2);
                endcase
            end
            rcv_cycle++;
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule

[files.f]
hw/rtl/smsc_pkg.sv
hw/rtl/smsc_knob_scale.sv
hw/rtl/settable_minute_second_clock_unit.sv
dv/tb.sv
